FILE: rtl/pct_pkg.sv
// shared types and constants for the percent decoder
`default_nettype none

package pct_pkg;

    // escape introducer character
    localparam logic [7:0] PCT_CHAR = 8'h25;

    // default number of bundles held between front and back
    localparam int PCT_QUEUE_DEPTH = 4;

    // escape tracking state
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // up to three output bytes produced by one input byte
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            last;
    } bundle_t;

endpackage

`default_nettype wire

FILE: rtl/pct_front.sv
// front end: tracks escapes and turns each input byte into at most one output bundle
`default_nettype none

module pct_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    output pct_pkg::bundle_t      bundle,
    output logic                  bundle_push
);
    import pct_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       is_hex;
    logic       opens_escape;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // letters sit at low nibble 1..6 in both cases
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c[6]) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = c[3:0];
        end
        return v;
    endfunction

    assign is_hex       = hex_ok(in_byte);
    assign opens_escape = (in_byte == PCT_CHAR) && !in_last;

    // classify the byte against the pending escape
    always_comb begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        bundle.count  = 2'd0;
        bundle.bytes  = '0;
        bundle.last   = in_last;
        unique case (phase_reg)
            PH_PCT: begin
                if (is_hex && in_last) begin
                    bundle.count    = 2'd2;
                    bundle.bytes[0] = PCT_CHAR;
                    bundle.bytes[1] = in_byte;
                    phase_next      = PH_IDLE;
                end else if (is_hex) begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end else if (opens_escape) begin
                    bundle.count    = 2'd1;
                    bundle.bytes[0] = PCT_CHAR;
                    phase_next      = PH_PCT;
                end else begin
                    bundle.count    = 2'd2;
                    bundle.bytes[0] = PCT_CHAR;
                    bundle.bytes[1] = in_byte;
                    phase_next      = PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (is_hex) begin
                    bundle.count    = 2'd1;
                    bundle.bytes[0] = {hex_val(held_reg), hex_val(in_byte)};
                    phase_next      = PH_IDLE;
                end else if (opens_escape) begin
                    bundle.count    = 2'd2;
                    bundle.bytes[0] = PCT_CHAR;
                    bundle.bytes[1] = held_reg;
                    phase_next      = PH_PCT;
                end else begin
                    bundle.count    = 2'd3;
                    bundle.bytes[0] = PCT_CHAR;
                    bundle.bytes[1] = held_reg;
                    bundle.bytes[2] = in_byte;
                    phase_next      = PH_IDLE;
                end
            end
            default: begin
                if (opens_escape) begin
                    phase_next = PH_PCT;
                end else begin
                    bundle.count    = 2'd1;
                    bundle.bytes[0] = in_byte;
                    phase_next      = PH_IDLE;
                end
            end
        endcase
    end

    assign bundle_push = in_fire && (bundle.count != 2'd0);

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (in_fire) begin
            phase_reg <= phase_next;
        end
    end

    // held digit, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pct_queue.sv
// small bundle queue between front and back
`default_nettype none

module pct_queue #(
    parameter int DEPTH = pct_pkg::PCT_QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  pct_pkg::bundle_t      push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output pct_pkg::bundle_t      pop_data
);
    import pct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_next;
    logic               push_ok;
    logic               pop_ok;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign push_ok   = push && !full;
    assign pop_ok    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pct_back.sv
// back end: serializes bundles into single output byte transfers
`default_nettype none

module pct_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_not_empty,
    input  pct_pkg::bundle_t      q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);
    import pct_pkg::*;

    bundle_t    cur_reg;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       at_end;
    logic       out_fire;

    assign at_end    = (idx_reg == cur_reg.count - 2'd1);
    assign out_fire  = cur_valid_reg && out_ready;
    assign out_valid = cur_valid_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_last  = cur_reg.last && at_end;

    // load a new bundle when empty or when the last byte leaves
    assign q_pop = q_not_empty && (!cur_valid_reg || (out_fire && at_end));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop) begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end else if (out_fire && at_end) begin
            cur_valid_next = 1'b0;
            idx_next       = 2'd0;
        end else if (out_fire) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // current bundle payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/percent_decoder.sv
// Streaming URL percent decoder, top level.
//
// Input channel s_*: one raw byte per transfer, s_in_last marks the end of a
// string. Output channel m_*: one decoded byte per transfer, m_out_last on
// the final byte of a string. A '%' with two hex digits becomes one byte;
// a broken escape is passed through literally and the breaking byte is
// decoded anew. One input byte yields zero to three output bytes.
//
// Throughput: one input byte per cycle as long as the bundle queue has room,
// and one output byte per cycle while m_ready is high and bundles are
// waiting; the output side sets the rate when an input expands into two or
// three bytes, and the queue of QUEUE_DEPTH bundles absorbs those bursts.
//
// Reset (aresetn low, synchronous) drops any pending escape and empties the
// queue and the output stage. When m_ready is low the output byte holds,
// the queue fills, and s_ready drops once it is full.
`default_nettype none

module percent_decoder #(
    parameter int QUEUE_DEPTH = pct_pkg::PCT_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last
);
    import pct_pkg::*;

    bundle_t front_bundle;
    bundle_t q_data;
    logic    front_push;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    logic    in_fire;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    // escape tracking and classification
    pct_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_byte     (s_in_byte),
        .in_last     (s_in_last),
        .bundle      (front_bundle),
        .bundle_push (front_push)
    );

    // decoupling queue
    pct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // output serializer
    pct_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_byte    (m_out_byte),
        .out_last    (m_out_last)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_percent_decoder.sv
// self-checking testbench for the streaming percent decoder
`default_nettype none

module tb_percent_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 84;
    localparam int SETTLE_CYCLES = 10;

    // one decoded byte as it should leave the block
    typedef struct {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    // tracks escape state and the decoded bytes still owed by the block
    class pct_decode_tracker;
        phase_t     phase;
        logic [7:0] held_digit;
        decoded_t   owed_bytes[$];
        int         mismatches;

        function new();
            phase      = PH_IDLE;
            held_digit = 8'h00;
            mismatches = 0;
        endfunction

        function bit is_hex(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                   (c >= "A" && c <= "F");
        endfunction

        function logic [3:0] nibble_of(logic [7:0] c);
            logic [7:0] v;
            if (c >= "0" && c <= "9") begin
                v = c - 8'h30;
            end else if (c >= "a" && c <= "f") begin
                v = c - 8'h57;
            end else begin
                v = c - 8'h37;
            end
            return v[3:0];
        endfunction

        function void owe(logic [7:0] data, logic last);
            decoded_t d;
            d.data = data;
            d.last = last;
            owed_bytes.push_back(d);
        endfunction

        // byte handled with nothing pending
        function void plain_byte(logic [7:0] b, logic last);
            if (b == PCT_CHAR && !last) begin
                phase = PH_PCT;
            end else begin
                owe(b, last);
                phase = PH_IDLE;
            end
        endfunction

        // note one accepted input transfer
        function void absorb_byte(logic [7:0] b, logic last);
            case (phase)
                PH_PCT: begin
                    if (is_hex(b)) begin
                        if (last) begin
                            owe(PCT_CHAR, 1'b0);
                            owe(b, 1'b1);
                            phase = PH_IDLE;
                        end else begin
                            held_digit = b;
                            phase      = PH_DIGIT;
                        end
                    end else begin
                        owe(PCT_CHAR, 1'b0);
                        plain_byte(b, last);
                    end
                end
                PH_DIGIT: begin
                    if (is_hex(b)) begin
                        owe({nibble_of(held_digit), nibble_of(b)}, last);
                        phase = PH_IDLE;
                    end else begin
                        owe(PCT_CHAR, 1'b0);
                        owe(held_digit, 1'b0);
                        plain_byte(b, last);
                    end
                end
                default: plain_byte(b, last);
            endcase
        endfunction

        // compare one output transfer with the oldest owed byte
        function void check_byte(logic [7:0] data, logic last);
            decoded_t d;
            if (owed_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected output: byte %h last %b", data, last);
                return;
            end
            d = owed_bytes.pop_front();
            if (d.data !== data || d.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected byte %h last %b, got byte %h last %b",
                             d.data, d.last, data, last);
            end
        endfunction

        function int owed();
            return owed_bytes.size();
        endfunction
    endclass

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_in_last  = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;
    int items_sent    = 0;

    pct_decode_tracker tracker = new();

    percent_decoder dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // transfer monitor, scoreboard hookup and stall counter
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.absorb_byte(s_in_byte, s_in_last);
            if (m_valid && m_ready)
                tracker.check_byte(m_out_byte, m_out_last);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("** percent_decoder: FAILED **");
        $finish;
    end

    // present one byte and hold it until the transfer happens
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // send a text string with the last mark on its final character
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // hold off the sender until every owed byte has come out
    task automatic drain_outputs();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.owed() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        string hexes = "0123456789abcdefABCDEF";
        string near  = "/:@G`g";
        int    r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return PCT_CHAR;
        else if (r < 65)
            return hexes[$urandom_range(0, hexes.len() - 1)];
        else if (r < 75)
            return near[$urandom_range(0, near.len() - 1)];
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // random strings, mostly escape-heavy, some plain noise
    task automatic random_strings(input int count);
        int target;
        int len;
        bit noise;
        target = items_sent + count;
        while (items_sent < target) begin
            len   = $urandom_range(1, 8);
            noise = ($urandom_range(0, 99) < 10);
            for (int i = 0; i < len; i++) begin
                if (noise)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                else
                    send_byte(pick_char(), i == len - 1);
            end
            if ($urandom_range(0, 11) == 0)
                drain_outputs();
        end
    endtask

    // main sequence
    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed strings covering each escape path
        send_idle_pct = 31;
        recv_idle_pct = 88;
        send_text("%41");
        send_text("%aF");
        send_text("%");
        send_text("%4");
        send_text("%4g");
        send_text("%%41");
        send_text("%4%20");
        send_text("%G");
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_text("%%");
        drain_outputs();

        // random phases with changing back-pressure
        random_strings(RANDOM_ITEMS);
        drain_outputs();
        send_idle_pct = 88;
        recv_idle_pct = 31;
        random_strings(RANDOM_ITEMS);
        drain_outputs();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_strings(RANDOM_ITEMS);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.owed() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.owed() == 0) begin
            $display("** percent_decoder: PASSED **");
        end else begin
            $display("** percent_decoder: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
